FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, command and status codes, and interface structs for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = $clog2(2 * DEPTH);
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;
    localparam int WORD_W     = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SIZE       = 3'd4,
        CMD_EMPTY      = 3'd5,
        CMD_FRONT      = 3'd6,
        CMD_BACK       = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_VALUE    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_ACCEPTED = 2'd3
    } status_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic              use_mem;
        logic [WORD_W-1:0] value;
    } ctrl_res_t;

endpackage

FILE: rtl/deq_store.sv
// ----------------------------------------------------------------------------
// deq_store
// Entry storage: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module deq_store (
    input  logic                           aclk,
    input  deq_pkg::mem_req_t              req,
    output logic [deq_pkg::DATA_WIDTH-1:0] rdata
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Head pointer and entry count, command decode, storage access and status.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 exec,
    input  deq_pkg::cmd_t        cmd,
    input  logic [31:0]          push_value,
    output deq_pkg::mem_req_t    req,
    output deq_pkg::ctrl_res_t   res
);
    import deq_pkg::*;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  tail_sum, last_sum;
    logic [ADDR_W-1:0] tail_idx, last_idx, head_dec;
    logic              is_empty, is_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (exec) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        is_empty = (count_reg == '0);
        is_full  = (count_reg == CNT_W'(DEPTH));

        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(tail_sum);
        last_sum = tail_sum - SUM_W'(1);
        last_idx = (last_sum >= SUM_W'(DEPTH)) ? ADDR_W'(last_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(last_sum);
        head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    end

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        req.we      = 1'b0;
        req.re      = 1'b0;
        req.addr    = head_reg;
        req.wdata   = DATA_WIDTH'(push_value);
        res.status  = ST_VALUE;
        res.use_mem = 1'b0;
        res.value   = '0;
        unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (is_full) begin
                    res.status = ST_FULL;
                end else begin
                    res.status = ST_ACCEPTED;
                    req.we     = exec;
                    count_next = count_reg + CNT_W'(1);
                    if (cmd == CMD_PUSH_FRONT) begin
                        head_next = head_dec;
                        req.addr  = head_dec;
                    end else begin
                        req.addr  = tail_idx;
                    end
                end
            end
            CMD_POP_FRONT, CMD_FRONT: begin
                if (is_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    req.re      = exec;
                    res.use_mem = 1'b1;
                    if (cmd == CMD_POP_FRONT) begin
                        head_next  = (head_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                      : head_reg + ADDR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            CMD_POP_BACK, CMD_BACK: begin
                if (is_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    req.re      = exec;
                    req.addr    = last_idx;
                    res.use_mem = 1'b1;
                    if (cmd == CMD_POP_BACK) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            CMD_SIZE: begin
                res.value = WORD_W'(count_reg);
            end
            CMD_EMPTY: begin
                res.value = WORD_W'(is_empty);
            end
            default: begin
                res.status = ST_VALUE;
            end
        endcase
    end

endmodule

FILE: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of data words in a circular buffer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one command per transaction, command in s_tuser, push word in
//   s_tdata. m_ channel: exactly one result per command, status in m_tuser,
//   popped/peeked word, count or empty flag in m_tdata.
//   A command is held in the input stage, then its result is registered in
//   the result stage and presented on m_ until it is taken.
//   Throughput: one command per cycle unless m_tready holds the result;
//   a command does its head/count update and single port access on advance.
//   The storage read is registered in the storage, so the result stage
//   selects between that read register and the computed value.
//   Reset clears the head pointer, the entry count and both pipeline stages;
//   storage contents are not cleared and are only read once written.
//   When m_tready is low the result holds, one more command may wait in the
//   input stage, and then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [1:0]  m_tuser    // [1:0] status
);
    import deq_pkg::*;

    logic                  in_valid_reg;
    cmd_t                  cmd_reg;
    logic [31:0]           push_reg;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic                  use_mem_reg;
    logic [WORD_W-1:0]     value_reg;
    logic                  advance;
    mem_req_t              req;
    ctrl_res_t             res;
    logic [DATA_WIDTH-1:0] rdata;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= cmd_t'(s_tuser);
            push_reg <= s_tdata;
        end
    end

    deq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .exec       (advance),
        .cmd        (cmd_reg),
        .push_value (push_reg),
        .req        (req),
        .res        (res)
    );

    deq_store u_store (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg  <= res.status;
            use_mem_reg <= res.use_mem;
            value_reg   <= res.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = use_mem_reg ? WORD_W'(rdata) : value_reg;

endmodule

FILE: sim/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Watches both stream channels of the double-ended queue. Every accepted
// command runs through a shadow deque that yields the expected status and
// word, and every accepted result is compared in order against them.
// ----------------------------------------------------------------------------
module deq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [2:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] result_value
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          mismatches,
    output int          results_due,
    output int          results_seen,
    output int          full_drops,
    output int          empty_answers,
    output int          peak_fill
);
    import deq_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] value;
    } deq_result_t;

    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    int                    shadow_head;
    int                    shadow_count;
    deq_result_t           answers_due [$];
    deq_result_t           oldest;
    deq_result_t           predicted;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch on result %0d: %s is %h, expected %h",
                     results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic deq_apply(input cmd_t cmd, input logic [31:0] word,
                             output deq_result_t res);
        int slot;
        res.status = ST_VALUE;
        res.value  = '0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                    full_drops++;
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        slot = shadow_head;
                    end else begin
                        slot = (shadow_head + shadow_count) % DEPTH;
                    end
                    shadow_words[slot] = DATA_WIDTH'(word);
                    shadow_count++;
                    res.status = ST_ACCEPTED;
                    if (shadow_count > peak_fill)
                        peak_fill = shadow_count;
                end
            end
            CMD_POP_FRONT, CMD_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                    empty_answers++;
                end else begin
                    res.value = WORD_W'(shadow_words[shadow_head]);
                    if (cmd == CMD_POP_FRONT) begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_count--;
                    end
                end
            end
            CMD_POP_BACK, CMD_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                    empty_answers++;
                end else begin
                    slot = (shadow_head + shadow_count - 1) % DEPTH;
                    res.value = WORD_W'(shadow_words[slot]);
                    if (cmd == CMD_POP_BACK)
                        shadow_count--;
                end
            end
            CMD_SIZE: res.value = WORD_W'(shadow_count);
            default:  res.value = (shadow_count == 0) ? 32'd1 : 32'd0;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_head   = 0;
            shadow_count  = 0;
            answers_due.delete();
            mismatches    = 0;
            results_seen  = 0;
            full_drops    = 0;
            empty_answers = 0;
            peak_fill     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    report_mismatch("result with no command outstanding",
                                    {30'd0, m_tuser}, 32'd0);
                end else begin
                    oldest = answers_due[0];
                    answers_due.delete(0);
                    if (m_tuser !== oldest.status)
                        report_mismatch("status", {30'd0, m_tuser},
                                        {30'd0, oldest.status});
                    if (m_tdata !== oldest.value)
                        report_mismatch("result_value", m_tdata, oldest.value);
                end
            end
            if (s_tvalid && s_tready) begin
                deq_apply(cmd_t'(s_tuser), s_tdata, predicted);
                answers_due = {answers_due, predicted};
            end
        end
        results_due = answers_due.size();
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives commands into double_ended_queue_top: a directed pass over the
// empty-queue and end cases, then random traffic that wanders near empty,
// fills the queue to full and keeps pushing, with varying idle and stall
// patterns and one long result hold-off. A checker module does the scoring.
// ----------------------------------------------------------------------------
module testbench;
    import deq_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MODE_SPAN    = 100;
    localparam int HOLD_AT      = 600;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] push_value
    logic [2:0]  s_tuser;   // [2:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] result_value
    logic [1:0]  m_tuser;   // [1:0] status

    int mismatches;
    int results_due;
    int results_seen;
    int full_drops;
    int empty_answers;
    int peak_fill;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_req   = 1'b0;
    int fill_level     = 0;
    int full_tries     = 0;
    int commands_sent  = 0;
    int quiet_cycles   = 0;

    always #2 aclk = ~aclk;

    double_ended_queue_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    deq_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .results_due   (results_due),
        .results_seen  (results_seen),
        .full_drops    (full_drops),
        .empty_answers (empty_answers),
        .peak_fill     (peak_fill)
    );

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    task automatic send_command(input cmd_t cmd, input logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        commands_sent++;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (fill_level < DEPTH)
                    fill_level++;
                else
                    full_tries++;
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (fill_level > 0)
                    fill_level--;
            end
            default: ;
        endcase
    endtask

    function automatic cmd_t pick_command(input int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return cmd_t'(3'($urandom_range(7)));
    endfunction

    task automatic send_random(input int push_pct, inout int idx);
        set_idling((idx / MODE_SPAN) % 4);
        if (idx == HOLD_AT)
            hold_off_req = 1'b1;
        send_command(pick_command(push_pct), $urandom);
        idx++;
    endtask

    always begin
        @(negedge aclk);
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge aclk);
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** double_ended_queue_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int rnd_idx;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_SIZE;
        m_tready = 1'b1;
        rnd_idx  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_command(CMD_POP_FRONT,  32'h1234_5678);
        send_command(CMD_POP_BACK,   32'hFFFF_FFFF);
        send_command(CMD_FRONT,      32'h0000_0000);
        send_command(CMD_BACK,       32'h8000_0001);
        send_command(CMD_SIZE,       32'hFFFF_FFFF);
        send_command(CMD_EMPTY,      32'h0000_0000);
        send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_command(CMD_PUSH_BACK,  32'h0000_0000);
        send_command(CMD_PUSH_FRONT, 32'hA5A5_A5A5);
        send_command(CMD_PUSH_BACK,  32'h5A5A_5A5A);
        send_command(CMD_SIZE,       32'h0000_0000);
        send_command(CMD_EMPTY,      32'hFFFF_FFFF);
        send_command(CMD_FRONT,      32'h0000_0000);
        send_command(CMD_BACK,       32'h0000_0000);
        send_command(CMD_POP_FRONT,  32'h0000_0000);
        send_command(CMD_POP_BACK,   32'h0000_0000);
        send_command(CMD_FRONT,      32'h0000_0000);
        send_command(CMD_BACK,       32'h0000_0000);
        send_command(CMD_POP_FRONT,  32'h0000_0000);
        send_command(CMD_POP_BACK,   32'h0000_0000);
        send_command(CMD_EMPTY,      32'h0000_0000);

        repeat (60) send_random(10, rnd_idx);
        while (full_tries < 12)
            send_random(90, rnd_idx);
        repeat (40) send_random(0, rnd_idx);
        s_tvalid <= 1'b0;

        while (results_due != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("checked %0d results of %0d commands, queue filled to %0d of %0d",
                 results_seen, commands_sent, peak_fill, DEPTH);
        $display("%0d pushes dropped on a full queue, %0d pops or peeks on an empty one",
                 full_drops, empty_answers);
        if (mismatches == 0 && results_due == 0) begin
            $display("** double_ended_queue_top: PASSED **");
        end else begin
            $display("** double_ended_queue_top: FAILED **");
        end
        $finish;
    end

endmodule
